// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the cipher RTL.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FBCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fbcm: implication check failed");

// Next-cycle implication.
`define FBCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fbcm: next-cycle check failed");

// Fixed-latency implication.
`define FBCM_ASSERT_DLY(lbl, clk, rstn, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##dly (cons)) \
        else $error("fbcm: latency check failed");

`endif

// ----- rtl/fbcm_pkg.sv -----
// Shared types, constants and the S-box layer of the Magma cipher block.
// Depends on nothing; imported by fbcm_round, fbcm_core and the top level.
package fbcm_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int ROT_LEFT    = 11;
    localparam logic [4:0] ROUND_LAST = 5'(ROUND_COUNT - 1);

    // chain_mode codes
    localparam logic [1:0] MODE_ECB = 2'd0;
    localparam logic [1:0] MODE_CBC = 2'd1;
    localparam logic [1:0] MODE_CFB = 2'd2;
    localparam logic [1:0] MODE_OFB = 2'd3;

    // register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_SK01 = 3'd0;
    localparam logic [2:0] REG_SK23 = 3'd1;
    localparam logic [2:0] REG_SK45 = 3'd2;
    localparam logic [2:0] REG_SK67 = 3'd3;
    localparam logic [2:0] REG_IV   = 3'd4;
    localparam logic [2:0] REG_MODE = 3'd5;
    localparam logic [2:0] REG_DIR  = 3'd6;

    typedef logic [7:0][31:0] key_array_t;

    typedef struct packed {
        logic start;
        logic decrypt;
        logic ack;
    } fbcm_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } fbcm_stat_t;

    localparam logic [3:0] SBOX [8][16] = '{
        '{4'hC, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
          4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h1},
        '{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
          4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
        '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
          4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
        '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
          4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
        '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
          4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
        '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
          4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
        '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
          4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
        '{4'h3, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
          4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'h4}
    };

    // Nibble n (n = 0 least significant) goes through S-box row n.
    function automatic logic [31:0] sbox_layer(input logic [31:0] din);
        logic [31:0] dout;
        dout = '0;
        for (int n = 0; n < 8; n++) begin
            dout[4*n +: 4] = SBOX[n][din[4*n +: 4]];
        end
        return dout;
    endfunction

endpackage

// ----- rtl/fbcm_round.sv -----
// One Magma round: key add, S-box layer, rotate left by 11, XOR.
// Depends on fbcm_pkg.
module fbcm_round (
    input  logic [31:0] half,
    input  logic [31:0] subkey,
    input  logic [31:0] other,
    output logic [31:0] mixed
);
    import fbcm_pkg::*;

    logic [31:0] sum;
    logic [31:0] sub;
    logic [31:0] rot;

    assign sum   = half + subkey;
    assign sub   = sbox_layer(sum);
    assign rot   = {sub[31-ROT_LEFT:0], sub[31:32-ROT_LEFT]};
    assign mixed = other ^ rot;

endmodule

// ----- rtl/fbcm_core.sv -----
// Round sequencer: runs one block through 32 rounds of the shared round unit.
// Depends on fbcm_pkg and fbcm_round.
module fbcm_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  fbcm_pkg::fbcm_ctrl_t ctrl,
    input  logic [63:0]         block_in,
    input  fbcm_pkg::key_array_t keys,
    output fbcm_pkg::fbcm_stat_t stat,
    output logic [63:0]         block_out
);
    import fbcm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  round_reg, round_next;
    logic        decrypt_reg, decrypt_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] right_reg, right_next;
    logic        fwd;
    logic [2:0]  key_idx;
    logic [31:0] mixed;

    // Forward key order for the first 24 rounds (encrypt) or first 8 (decrypt).
    assign fwd     = decrypt_reg ? (round_reg[4:3] == 2'b00) : (round_reg[4:3] != 2'b11);
    assign key_idx = fwd ? round_reg[2:0] : ~round_reg[2:0];

    fbcm_round u_round (
        .half   (right_reg),
        .subkey (keys[key_idx]),
        .other  (left_reg),
        .mixed  (mixed)
    );

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        decrypt_next = decrypt_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (ctrl.start) begin
                    left_next    = block_in[63:32];
                    right_next   = block_in[31:0];
                    decrypt_next = ctrl.decrypt;
                    round_next   = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN: begin
                left_next  = right_reg;
                right_next = mixed;
                round_next = round_reg + 5'd1;
                if (round_reg == ROUND_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (ctrl.ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            round_reg <= '0;
        end else begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge aclk) begin
        decrypt_reg <= decrypt_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
    end

    // The last round leaves the halves unswapped: right half goes on top.
    assign block_out = {right_reg, left_reg};
    assign stat.idle = (state_reg == ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);

endmodule

// ----- rtl/feistel_block_cipher_modes.sv -----
// Top level: register file, ECB/CBC/CFB/OFB chaining and the output register.
// Depends on fbcm_pkg, fbcm_core, fbcm_round and assert_macros.svh.
//
//   channel   direction  handshake            payload
//   config    in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//   s_        in         s_valid/s_ready      s_data_block, s_first_block
//   m_        out        m_valid/m_ready      m_result_block
//
// A block goes from accept through 32 rounds in the single round unit (one round
// per cycle), then a done state that hands the result to the output register,
// then back to idle before the next block is accepted.
// Reset is synchronous on aresetn low; it clears config registers, output valid and chain value.
// A held output stalls only the finished core; the next block is taken
// while the previous result waits in m_result_block.
`include "assert_macros.svh"

module feistel_block_cipher_modes (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_data_block,
    input  logic        s_first_block,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_block
);
    import fbcm_pkg::*;

    // configuration registers
    logic [63:0] sk01_reg, sk23_reg, sk45_reg, sk67_reg;
    logic [63:0] iv_reg;
    logic [1:0]  mode_reg;
    logic        dir_reg;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    // per-transaction working registers
    logic [63:0] chain_reg, chain_next;
    logic [63:0] blk_reg;
    logic [63:0] cv_reg;
    logic [1:0]  op_mode_reg;
    logic        op_dir_reg;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_result_block_reg, m_result_next;

    logic        accept;
    logic        out_load;
    logic [63:0] chain_sel;
    logic [63:0] core_in;
    logic [63:0] core_out;
    key_array_t  keys;
    fbcm_ctrl_t  ctrl;
    fbcm_stat_t  stat;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sk01_reg <= '0;
            sk23_reg <= '0;
            sk45_reg <= '0;
            sk67_reg <= '0;
            iv_reg   <= '0;
            mode_reg <= MODE_ECB;
            dir_reg  <= 1'b0;
        end else if (cfg_wr) begin
            // drop writes to the unused index
            unique case (reg_idx)
                REG_SK01: sk01_reg <= pwdata;
                REG_SK23: sk23_reg <= pwdata;
                REG_SK45: sk45_reg <= pwdata;
                REG_SK67: sk67_reg <= pwdata;
                REG_IV:   iv_reg   <= pwdata;
                REG_MODE: mode_reg <= pwdata[1:0];
                REG_DIR:  dir_reg  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SK01: prdata = sk01_reg;
            REG_SK23: prdata = sk23_reg;
            REG_SK45: prdata = sk45_reg;
            REG_SK67: prdata = sk67_reg;
            REG_IV:   prdata = iv_reg;
            REG_MODE: prdata = {62'd0, mode_reg};
            REG_DIR:  prdata = {63'd0, dir_reg};
            default:  prdata = '0;
        endcase
    end

    // k0 lives in the upper half of subkeys_0_1, k7 in the lower half of subkeys_6_7
    assign keys = {sk67_reg[31:0], sk67_reg[63:32], sk45_reg[31:0], sk45_reg[63:32],
                   sk23_reg[31:0], sk23_reg[63:32], sk01_reg[31:0], sk01_reg[63:32]};

    // ---------------- input side ----------------
    assign s_ready = stat.idle;
    assign accept  = s_valid & s_ready;

    // A first block of a chained mode restarts from the IV; ECB ignores the flag.
    assign chain_sel = ((mode_reg != MODE_ECB) && s_first_block) ? iv_reg : chain_reg;

    always_comb begin
        unique case (mode_reg)
            MODE_ECB: core_in = s_data_block;
            MODE_CBC: core_in = dir_reg ? s_data_block : (s_data_block ^ chain_sel);
            MODE_CFB: core_in = chain_sel;
            MODE_OFB: core_in = chain_sel;
            default:  core_in = s_data_block;
        endcase
    end

    // Only ECB and CBC run the cipher backwards; the stream modes always encrypt.
    assign ctrl.start   = accept;
    assign ctrl.decrypt = dir_reg & ((mode_reg == MODE_ECB) | (mode_reg == MODE_CBC));
    assign ctrl.ack     = out_load;

    always_ff @(posedge aclk) begin
        if (accept) begin
            blk_reg     <= s_data_block;
            cv_reg      <= chain_sel;
            op_mode_reg <= mode_reg;
            op_dir_reg  <= dir_reg;
        end
    end

    fbcm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .block_in  (core_in),
        .keys      (keys),
        .stat      (stat),
        .block_out (core_out)
    );

    // ---------------- finish: mode post-processing ----------------
    // Move the core result out once the output register is free or draining.
    assign out_load = stat.done & (~m_valid_reg | m_ready);

    always_comb begin
        chain_next    = chain_reg;
        m_result_next = core_out;
        unique case (op_mode_reg)
            MODE_ECB: begin
                m_result_next = core_out;
            end
            MODE_CBC: begin
                if (op_dir_reg) begin
                    m_result_next = core_out ^ cv_reg;
                    chain_next    = blk_reg;
                end else begin
                    m_result_next = core_out;
                    chain_next    = core_out;
                end
            end
            MODE_CFB: begin
                m_result_next = blk_reg ^ core_out;
                chain_next    = op_dir_reg ? blk_reg : (blk_reg ^ core_out);
            end
            MODE_OFB: begin
                m_result_next = blk_reg ^ core_out;
                chain_next    = core_out;
            end
            default: begin
                m_result_next = core_out;
            end
        endcase
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            chain_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (out_load) begin
                chain_reg <= chain_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_result_block_reg <= m_result_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_block = m_result_block_reg;

    // ---------------- checks ----------------
    // An accepted block occupies the core and blocks the input next cycle.
    `FBCM_ASSERT_NXT(a_accept_busy, aclk, aresetn, accept, !s_ready && !stat.done)
    // Hold a finished result in the core while the output stays blocked.
    `FBCM_ASSERT_NXT(a_done_hold, aclk, aresetn, stat.done && m_valid && !m_ready, stat.done)
    // Exactly 32 rounds sit between accept and a finished core.
    `FBCM_ASSERT_DLY(a_round_count, aclk, aresetn, accept, 33, stat.done)

endmodule

// ----- bench/feistel_block_cipher_modes_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the Magma block cipher with ECB/CBC/CFB/OFB chaining.
// Depends on fbcm_pkg (mode codes, register indexes) and feistel_block_cipher_modes.

module feistel_block_cipher_modes_tb;
    import fbcm_pkg::*;

    localparam time CLK_PERIOD = 8ns;
    // Leave margin for the block to finish and go idle before touching registers.
    localparam int SETTLE_CYCLES = 48;
    // Index past the end of the register map: writes there must be dropped.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam bit DIR_ENCRYPT = 1'b0;
    localparam bit DIR_DECRYPT = 1'b1;
    localparam logic [63:0] ALL_ONES = '1;

    // Magma substitution rows; nibble n of the round input uses row n.
    localparam logic [3:0] CIPHER_SBOX [8][16] = '{
        '{4'hC, 4'hA, 4'h9, 4'h2, 4'hD, 4'h8, 4'h0, 4'hE,
          4'h6, 4'hB, 4'h1, 4'hC, 4'h7, 4'hF, 4'h5, 4'h1},
        '{4'hE, 4'hB, 4'h4, 4'hC, 4'h6, 4'hD, 4'hF, 4'hA,
          4'h2, 4'h3, 4'h8, 4'h1, 4'h0, 4'h7, 4'h5, 4'h9},
        '{4'h5, 4'h8, 4'h1, 4'hD, 4'hA, 4'h3, 4'h4, 4'h2,
          4'hE, 4'hF, 4'hC, 4'h7, 4'h6, 4'h0, 4'h9, 4'hB},
        '{4'h7, 4'hD, 4'hA, 4'h1, 4'h0, 4'h8, 4'h9, 4'hF,
          4'hE, 4'h4, 4'h6, 4'hC, 4'hB, 4'h2, 4'h5, 4'h3},
        '{4'h6, 4'hC, 4'h7, 4'h1, 4'h5, 4'hF, 4'hD, 4'h8,
          4'h4, 4'hA, 4'h9, 4'hE, 4'h0, 4'h3, 4'hB, 4'h2},
        '{4'h4, 4'hB, 4'hA, 4'h0, 4'h7, 4'h2, 4'h1, 4'hD,
          4'h3, 4'h6, 4'h8, 4'h5, 4'h9, 4'hC, 4'hF, 4'hE},
        '{4'hD, 4'hB, 4'h4, 4'h1, 4'h3, 4'hF, 4'h5, 4'h9,
          4'h0, 4'hA, 4'hE, 4'h7, 4'h6, 4'h8, 4'h2, 4'hC},
        '{4'h3, 4'hF, 4'hD, 4'h0, 4'h5, 4'h7, 4'hA, 4'h4,
          4'h9, 4'h2, 4'h3, 4'hE, 4'h6, 4'hB, 4'h8, 4'h4}
    };

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_data_block;
    logic        s_first_block;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_block;

    // Shadow copy of the register file and of the chaining register.
    logic [63:0] key_pair [4];
    logic [63:0] iv_shadow;
    logic [1:0]  mode_shadow;
    bit          dir_shadow;
    logic [63:0] chain_shadow;

    // Result blocks still owed by the block, oldest first.
    logic [63:0] pending_blocks [$];

    int error_count;
    int blocks_sent;
    int blocks_checked;
    int mode_blocks [4];

    // Sender and receiver pacing knobs, changed by the tests.
    int gap_max;
    int burst_left;
    int stall_pct;
    int hold_cycles;

    feistel_block_cipher_modes dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_block   (s_data_block),
        .s_first_block  (s_first_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_block (m_result_block)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run (524 blocks, each with the
    // core rounds plus sender gaps and receiver stalls).
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------

    // One Feistel round function: add key, substitute nibbles, rotate by 11.
    function automatic logic [31:0] round_mix(input logic [31:0] half,
                                              input logic [31:0] subkey);
        logic [31:0] sum;
        logic [31:0] subst;
        sum = half + subkey;
        for (int n = 0; n < 8; n++) begin
            subst[4*n +: 4] = CIPHER_SBOX[n][sum[4*n +: 4]];
        end
        return {subst[20:0], subst[31:21]};
    endfunction

    // Full 32-round Magma transform with the current shadow subkeys.
    function automatic logic [63:0] magma_transform(input logic [63:0] blk,
                                                    input bit decrypt);
        logic [31:0] subkey [8];
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] mixed;
        int          sel;
        for (int p = 0; p < 4; p++) begin
            subkey[2*p]     = key_pair[p][63:32];
            subkey[2*p + 1] = key_pair[p][31:0];
        end
        left  = blk[63:32];
        right = blk[31:0];
        for (int r = 0; r < 32; r++) begin
            // Encrypt: k0..k7 three times then k7..k0; decrypt is the mirror.
            if (!decrypt) sel = (r < 24) ? (r % 8) : (31 - r);
            else          sel = (r < 8)  ? r       : (7 - (r % 8));
            mixed = left ^ round_mix(right, subkey[sel]);
            left  = right;
            right = mixed;
        end
        // Last round leaves the halves unswapped.
        return {right, left};
    endfunction

    // Advance the chaining shadow by one block and return the output block.
    function automatic logic [63:0] chained_result(input logic [63:0] blk,
                                                   input logic first);
        logic [63:0] chain_in;
        logic [63:0] res;
        if (mode_shadow != MODE_ECB && first) chain_shadow = iv_shadow;
        chain_in = chain_shadow;
        case (mode_shadow)
            MODE_ECB: begin
                res = magma_transform(blk, dir_shadow);
            end
            MODE_CBC: begin
                if (dir_shadow == DIR_ENCRYPT) begin
                    res = magma_transform(blk ^ chain_in, DIR_ENCRYPT);
                    chain_shadow = res;
                end else begin
                    res = magma_transform(blk, DIR_DECRYPT) ^ chain_in;
                    chain_shadow = blk;
                end
            end
            MODE_CFB: begin
                res = blk ^ magma_transform(chain_in, DIR_ENCRYPT);
                chain_shadow = (dir_shadow == DIR_DECRYPT) ? blk : res;
            end
            default: begin
                // OFB: keystream is independent of direction.
                chain_shadow = magma_transform(chain_in, DIR_ENCRYPT);
                res = blk ^ chain_shadow;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------

    // Setup phase then access phase; the register lands at the access edge.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_SK01: key_pair[0] = value;
            REG_SK23: key_pair[1] = value;
            REG_SK45: key_pair[2] = value;
            REG_SK67: key_pair[3] = value;
            REG_IV:   iv_shadow   = value;
            REG_MODE: mode_shadow = value[1:0];
            REG_DIR:  dir_shadow  = value[0];
            default:  ;
        endcase
    endtask

    task automatic load_keys(input logic [63:0] k01, input logic [63:0] k23,
                             input logic [63:0] k45, input logic [63:0] k67);
        write_reg(REG_SK01, k01);
        write_reg(REG_SK23, k23);
        write_reg(REG_SK45, k45);
        write_reg(REG_SK67, k67);
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one block, hold it until accepted, then record its prediction.
    task automatic send_block(input logic [63:0] blk, input logic first);
        int gap;
        @(negedge aclk);
        s_valid       = 1'b1;
        s_data_block  = blk;
        s_first_block = first;
        do @(posedge aclk); while (!s_ready);
        pending_blocks = {pending_blocks, chained_result(blk, first)};
        mode_blocks[mode_shadow]++;
        blocks_sent++;
        // Bursts of back-to-back transactions separated by random gaps.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(8, 1);
            gap = $urandom_range(gap_max, 0);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Drop valid, drain every owed result, then give the core time to go idle.
    task automatic settle;
        @(negedge aclk);
        s_valid = 1'b0;
        burst_left = 0;
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [63:0] random_block;
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver: stall runs of random length, plus a counted hold-off on request.
    initial begin
        int stall_run;
        stall_run = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready = 1'b0;
            end else if (stall_run > 0) begin
                stall_run--;
                m_ready = 1'b0;
            end else if ($urandom_range(99, 0) < stall_pct) begin
                stall_run = $urandom_range(12, 0);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Compare every result transaction against the oldest prediction.
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result expected none actual %h",
                         $time, m_result_block);
            end else begin
                want = pending_blocks.pop_front();
                blocks_checked++;
                if (m_result_block !== want) begin
                    error_count++;
                    $display("%0t: result_block mismatch expected %h actual %h",
                             $time, want, m_result_block);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Chained mode before any first block: chaining starts from the cleared value.
    task automatic test_chain_without_first_block;
        write_reg(REG_MODE, 64'(MODE_CBC));
        send_block('0, 1'b0);
        send_block(ALL_ONES, 1'b0);
        settle();
    endtask

    // Every mode in both directions, with extreme keys and data and a fixed IV.
    task automatic test_mode_sweep;
        load_keys(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        write_reg(REG_IV, 64'h0123_4567_89AB_CDEF);
        for (int m = 0; m < 4; m++) begin
            for (int d = 0; d < 2; d++) begin
                write_reg(REG_MODE, 64'(m));
                write_reg(REG_DIR, 64'(d ? DIR_DECRYPT : DIR_ENCRYPT));
                send_block(d ? '0 : ALL_ONES, 1'b1);
                send_block(64'h8000_0000_0000_0001, 1'b0);
                settle();
            end
        end
    endtask

    // New keys and direction in the middle of a message keep the held chain value.
    task automatic test_change_within_message;
        write_reg(REG_MODE, 64'(MODE_CBC));
        write_reg(REG_DIR, 64'(DIR_ENCRYPT));
        write_reg(REG_IV, random_block());
        send_block(random_block(), 1'b1);
        send_block(random_block(), 1'b0);
        settle();
        load_keys(random_block(), '0, random_block(), 64'h5555_AAAA_5555_AAAA);
        write_reg(REG_DIR, 64'(DIR_DECRYPT));
        send_block(random_block(), 1'b0);
        send_block(random_block(), 1'b0);
        settle();
    endtask

    // Oversized mode/direction values are masked; an unmapped index is ignored.
    task automatic test_masking_and_unmapped_index;
        write_reg(REG_MODE, ALL_ONES);
        write_reg(REG_DIR, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(REG_UNUSED, ALL_ONES);
        send_block(random_block(), 1'b1);
        send_block(random_block(), 1'b0);
        settle();
    endtask

    // Long output hold-off while the sender keeps offering: the input must stall.
    task automatic test_output_holdoff;
        gap_max = 0;
        stall_pct = 0;
        write_reg(REG_MODE, 64'(MODE_CFB));
        write_reg(REG_DIR, 64'(DIR_ENCRYPT));
        @(posedge aclk);
        hold_cycles = 400;
        for (int i = 0; i < 20; i++) send_block(random_block(), i == 0);
        settle();
    endtask

    // Random phases: fresh registers, then messages of random length and content.
    task automatic test_random_messages;
        int          msg_left;
        logic [63:0] blk;
        logic        first;
        for (int phase = 0; phase < 12; phase++) begin
            // Phases 0..7 walk all mode/direction pairs; the rest are random.
            if (phase == 0)      load_keys('0, '0, '0, '0);
            else if (phase == 1) load_keys(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
            else load_keys(random_block(), random_block(), random_block(), random_block());
            write_reg(REG_IV, (phase == 2) ? ALL_ONES : random_block());
            write_reg(REG_MODE, (phase < 8) ? 64'(phase % 4) : 64'($urandom_range(3, 0)));
            write_reg(REG_DIR, (phase < 8) ? 64'(phase / 4) : 64'($urandom_range(1, 0)));
            // Every third phase runs with no idling on either side.
            if (phase % 3 == 0) begin
                gap_max = 0;
                stall_pct = 0;
            end else begin
                gap_max = $urandom_range(6, 1);
                stall_pct = $urandom_range(60, 5);
            end
            msg_left = 0;
            for (int i = 0; i < 40; i++) begin
                if (msg_left == 0) begin
                    msg_left = $urandom_range(10, 1);
                    first = 1'b1;
                end else begin
                    // Occasionally restart a message early.
                    first = ($urandom_range(19, 0) == 0);
                end
                msg_left--;
                case ($urandom_range(15, 0))
                    0:       blk = '0;
                    1:       blk = ALL_ONES;
                    default: blk = random_block();
                endcase
                send_block(blk, first);
            end
            settle();
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_data_block  = '0;
        s_first_block = 1'b0;
        for (int p = 0; p < 4; p++) key_pair[p] = '0;
        iv_shadow     = '0;
        mode_shadow   = MODE_ECB;
        dir_shadow    = DIR_ENCRYPT;
        chain_shadow  = '0;
        error_count   = 0;
        blocks_sent   = 0;
        blocks_checked = 0;
        for (int m = 0; m < 4; m++) mode_blocks[m] = 0;
        gap_max       = 3;
        burst_left    = 0;
        stall_pct     = 20;
        hold_cycles   = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(posedge aclk);

        test_chain_without_first_block();
        test_mode_sweep();
        test_change_within_message();
        test_masking_and_unmapped_index();
        test_output_holdoff();
        test_random_messages();

        $display("Covered %0d blocks (%0d checked): ECB %0d, CBC %0d, CFB %0d, OFB %0d",
                 blocks_sent, blocks_checked, mode_blocks[MODE_ECB],
                 mode_blocks[MODE_CBC], mode_blocks[MODE_CFB], mode_blocks[MODE_OFB]);
        $display("Both directions, register changes mid-message, output hold-off.");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fbcm_pkg.sv
rtl/fbcm_round.sv
rtl/fbcm_core.sv
rtl/feistel_block_cipher_modes.sv
bench/feistel_block_cipher_modes_tb.sv
